FILE: design/apd_pkg.sv
`default_nettype none

package apd_pkg;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int PEAK_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // default samples per window
    localparam int WINDOW_DEFAULT = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PICKUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST   = 2'd1;

    // register reset values
    localparam logic [CFG_W-1:0] PICKUP_RESET = 16'd5000;
    localparam logic [CFG_W-1:0] REST_RESET   = 16'd100;

    // start values of the running extremes
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // pipeline controls shared by the axis slices
    typedef struct packed {
        logic acc_en;   // sample transfer into the accumulators
        logic close;    // that sample is the last of its window
        logic win_adv;  // closed window moves to the average stage
    } axis_ctrl_t;

endpackage

`default_nettype wire

FILE: design/apd_axis.sv
`default_nettype none

module apd_axis #(
    parameter int WINDOW = apd_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire apd_pkg::axis_ctrl_t                    ctrl,
    input  wire logic signed [apd_pkg::SAMPLE_W-1:0]    sample,
    output logic        [apd_pkg::PEAK_W-1:0]           peak
);

    localparam int LOG_W   = $clog2(WINDOW);
    localparam int SUM_W   = apd_pkg::SAMPLE_W + LOG_W;
    localparam int MAG_W   = SUM_W;
    localparam int SHIFT   = MAG_W + LOG_W;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int QUO_W   = PROD_W - SHIFT;
    localparam longint RECIP_L = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int AVG_W   = apd_pkg::SAMPLE_W + 1;
    localparam int DEV_W   = apd_pkg::SAMPLE_W + 2;
    localparam logic signed [DEV_W-1:0] PEAK_TOP = DEV_W'((1 << apd_pkg::PEAK_W) - 1);

    // running accumulators
    logic signed [apd_pkg::SAMPLE_W-1:0] acc_min_reg, acc_min_next;
    logic signed [apd_pkg::SAMPLE_W-1:0] acc_max_reg, acc_max_next;
    logic signed [SUM_W-1:0]             acc_sum_reg, acc_sum_next;

    // closed window
    logic signed [apd_pkg::SAMPLE_W-1:0] win_min_reg;
    logic signed [apd_pkg::SAMPLE_W-1:0] win_max_reg;
    logic signed [SUM_W-1:0]             win_sum_reg;

    // average stage
    logic signed [AVG_W-1:0]             avg_reg, avg_next;
    logic signed [apd_pkg::SAMPLE_W-1:0] avg_min_reg;
    logic signed [apd_pkg::SAMPLE_W-1:0] avg_max_reg;

    // divide helpers
    logic                                sum_neg;
    logic [MAG_W-1:0]                    sum_mag;
    logic [PROD_W-1:0]                   prod;
    logic [QUO_W-1:0]                    quo;
    logic signed [AVG_W-1:0]             quo_s;

    // deviation helpers
    logic signed [DEV_W-1:0]             below;
    logic signed [DEV_W-1:0]             above;
    logic signed [DEV_W-1:0]             dev;

    // running min, max and sum including the new sample
    always_comb
    begin
        acc_min_next = (sample < acc_min_reg) ? sample : acc_min_reg;
        acc_max_next = (sample > acc_max_reg) ? sample : acc_max_reg;
        acc_sum_next = acc_sum_reg + SUM_W'(sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_min_reg <= apd_pkg::SAMPLE_MAX;
            acc_max_reg <= apd_pkg::SAMPLE_MIN;
            acc_sum_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            if (ctrl.close)
            begin
                acc_min_reg <= apd_pkg::SAMPLE_MAX;
                acc_max_reg <= apd_pkg::SAMPLE_MIN;
                acc_sum_reg <= '0;
            end
            else
            begin
                acc_min_reg <= acc_min_next;
                acc_max_reg <= acc_max_next;
                acc_sum_reg <= acc_sum_next;
            end
        end
    end

    // capture the finished window
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en && ctrl.close)
        begin
            win_min_reg <= acc_min_next;
            win_max_reg <= acc_max_next;
            win_sum_reg <= acc_sum_next;
        end
    end

    // sum / WINDOW toward zero: reciprocal multiply on the magnitude
    always_comb
    begin
        sum_neg  = win_sum_reg[SUM_W-1];
        sum_mag  = sum_neg ? MAG_W'(-win_sum_reg) : MAG_W'(win_sum_reg);
        prod     = PROD_W'(sum_mag) * PROD_W'(RECIP);
        quo      = prod[SHIFT +: QUO_W];
        quo_s    = AVG_W'(quo);
        avg_next = sum_neg ? -quo_s : quo_s;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.win_adv)
        begin
            avg_reg     <= avg_next;
            avg_min_reg <= win_min_reg;
            avg_max_reg <= win_max_reg;
        end
    end

    // larger deviation from the average, clamped to the peak range
    always_comb
    begin
        below = DEV_W'(avg_reg) - DEV_W'(avg_min_reg);
        above = DEV_W'(avg_max_reg) - DEV_W'(avg_reg);
        dev   = (below > above) ? below : above;
        if (dev < 0)
        begin
            peak = '0;
        end
        else if (dev > PEAK_TOP)
        begin
            peak = '1;
        end
        else
        begin
            peak = apd_pkg::PEAK_W'(dev);
        end
    end

endmodule

`default_nettype wire

FILE: design/accel_pickup_detector_unit.sv
// a window's result moves through the window, average and output registers after its last sample
// throughput: one sample per cycle while in_ready is high, one result per WINDOW samples
// the window divide is a reciprocal multiply in its own stage, the threshold test in the next
// reset: thresholds return to 5000 and 100, accumulators clear, the flag goes to resting,
// and the pipeline empties
`default_nettype none

module accel_pickup_detector_unit #(
    parameter int WINDOW = apd_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [apd_pkg::SAMPLE_W-1:0]   accel_x,
    input  wire logic signed [apd_pkg::SAMPLE_W-1:0]   accel_y,
    input  wire logic signed [apd_pkg::SAMPLE_W-1:0]   accel_z,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic        [apd_pkg::PEAK_W-1:0]          peak_x,
    output logic        [apd_pkg::PEAK_W-1:0]          peak_y,
    output logic        [apd_pkg::PEAK_W-1:0]          peak_z,
    output logic                                       picked_up,
    input  wire logic                                  cfg_wr_en,
    input  wire logic   [apd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic   [apd_pkg::CFG_W-1:0]           cfg_data
);

    localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

    logic [apd_pkg::CFG_W-1:0]  pickup_reg;
    logic [apd_pkg::CFG_W-1:0]  rest_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       win_vld_reg, win_vld_next;
    logic                       avg_vld_reg, avg_vld_next;
    logic                       out_vld_reg, out_vld_next;
    logic                       held_flag_reg, held_flag_next;
    logic [apd_pkg::PEAK_W-1:0] peak_x_reg, peak_y_reg, peak_z_reg;

    logic                       out_free, avg_free, win_free;
    logic                       avg_adv, win_adv;
    logic                       take, close;
    logic                       any_high, all_low;
    logic [apd_pkg::PEAK_W-1:0] pk_x, pk_y, pk_z;
    apd_pkg::axis_ctrl_t        ctrl;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pickup_reg <= apd_pkg::PICKUP_RESET;
            rest_reg   <= apd_pkg::REST_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                apd_pkg::REG_PICKUP: pickup_reg <= cfg_data;
                apd_pkg::REG_REST:   rest_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // pipeline flow control
    always_comb
    begin
        out_free = !out_vld_reg || out_ready;
        avg_adv  = avg_vld_reg && out_free;
        avg_free = !avg_vld_reg || out_free;
        win_adv  = win_vld_reg && avg_free;
        win_free = !win_vld_reg || avg_free;
        in_ready = win_free;
        take     = in_valid && in_ready;
        close    = take && (count_reg == CNT_LAST);

        ctrl.acc_en  = take;
        ctrl.close   = close;
        ctrl.win_adv = win_adv;

        win_vld_next = close ? 1'b1 : (win_adv ? 1'b0 : win_vld_reg);
        avg_vld_next = win_adv ? 1'b1 : (avg_adv ? 1'b0 : avg_vld_reg);
        out_vld_next = avg_adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    end

    // per-axis accumulate, divide and deviation
    apd_axis #(.WINDOW(WINDOW)) u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (accel_x),
        .peak   (pk_x)
    );

    apd_axis #(.WINDOW(WINDOW)) u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (accel_y),
        .peak   (pk_y)
    );

    apd_axis #(.WINDOW(WINDOW)) u_axis_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (accel_z),
        .peak   (pk_z)
    );

    // hysteresis on the three peaks
    always_comb
    begin
        any_high = (pk_x > pickup_reg) || (pk_y > pickup_reg) || (pk_z > pickup_reg);
        all_low  = (pk_x < rest_reg) && (pk_y < rest_reg) && (pk_z < rest_reg);
        held_flag_next = held_flag_reg ? !all_low : any_high;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            win_vld_reg   <= 1'b0;
            avg_vld_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
            held_flag_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg <= close ? '0 : count_reg + 1'b1;
            end
            win_vld_reg <= win_vld_next;
            avg_vld_reg <= avg_vld_next;
            out_vld_reg <= out_vld_next;
            if (avg_adv)
            begin
                held_flag_reg <= held_flag_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (avg_adv)
        begin
            peak_x_reg <= pk_x;
            peak_y_reg <= pk_y;
            peak_z_reg <= pk_z;
        end
    end

    assign out_valid = out_vld_reg;
    assign peak_x    = peak_x_reg;
    assign peak_y    = peak_y_reg;
    assign peak_z    = peak_z_reg;
    assign picked_up = held_flag_reg;

endmodule

`default_nettype wire
